/* design/ipv4rhf_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4rhf_pkg
// Shared types and constants for the IPv4 receive header filter.
// ----------------------------------------------------------------------------
package ipv4rhf_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int COUNT_W      = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [7:0]         PROTO_ICMP  = 8'd1;
    localparam logic [7:0]         PROTO_UDP   = 8'd17;
    localparam logic [3:0]         IP_VERSION4 = 4'd4;
    localparam logic [3:0]         IHL_NO_OPTS = 4'd5;
    localparam logic [4:0]         FRAG_HI_MASK = 5'h1F;

    typedef enum logic [3:0] {
        V_ICMP      = 4'd0,
        V_UDP       = 4'd1,
        V_OTHER     = 4'd2,
        V_SHORT_HDR = 4'd3,
        V_SHORT_PKT = 4'd4,
        V_VERSION   = 4'd5,
        V_IHL       = 4'd6,
        V_DEST      = 4'd7,
        V_FRAG      = 4'd8
    } t_verdict;

    typedef logic [7:0] t_header [HEADER_BYTES];

    typedef struct packed {
        t_verdict     verdict;
        logic         learn_source;
        logic [31:0]  source_ip;
        logic [7:0]   protocol_number;
        logic [15:0]  total_length;
        logic [15:0]  payload_length;
    } t_result;

endpackage

/* design/ipv4rhf_in_if.sv */
// ----------------------------------------------------------------------------
// ipv4rhf_in_if
// Byte request channel into the IPv4 receive header filter.
// ----------------------------------------------------------------------------
interface ipv4rhf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/ipv4rhf_out_if.sv */
// ----------------------------------------------------------------------------
// ipv4rhf_out_if
// Verdict request channel out of the IPv4 receive header filter.
// ----------------------------------------------------------------------------
interface ipv4rhf_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  verdict;
    logic        learn_source;
    logic [31:0] source_ip;
    logic [7:0]  protocol_number;
    logic [15:0] total_length;
    logic [15:0] payload_length;

    modport source (output valid, output verdict, output learn_source, output source_ip,
                    output protocol_number, output total_length, output payload_length,
                    input ready);
    modport sink   (input valid, input verdict, input learn_source, input source_ip,
                    input protocol_number, input total_length, input payload_length,
                    output ready);
endinterface

/* design/ipv4rhf_judge.sv */
// ----------------------------------------------------------------------------
// ipv4rhf_judge
// Header checks and classification for the final byte of a packet.
// ----------------------------------------------------------------------------
module ipv4rhf_judge (
    input  ipv4rhf_pkg::t_header               i_store,
    input  logic [7:0]                         i_data_byte,
    input  logic [ipv4rhf_pkg::COUNT_W-1:0]    i_count,
    input  logic [31:0]                        i_local_addr,
    output ipv4rhf_pkg::t_result               o_result
);
    import ipv4rhf_pkg::*;

    logic [7:0]         hdr [HEADER_BYTES];
    logic [COUNT_W-1:0] size;
    logic [3:0]         version;
    logic [3:0]         ihl;
    logic [12:0]        frag;
    logic [31:0]        dst;
    logic [15:0]        tlen;

    // The final byte may itself be the last header byte, so it is forwarded.
    always_comb begin
        for (int i = 0; i < HEADER_BYTES; i++) begin
            hdr[i] = (i_count == COUNT_W'(i)) ? i_data_byte : i_store[i];
        end
    end

    assign size    = (i_count == COUNT_MAX) ? COUNT_MAX : i_count + COUNT_W'(1);
    assign version = hdr[0][7:4];
    assign ihl     = hdr[0][3:0];
    assign frag    = {hdr[6][4:0] & FRAG_HI_MASK, hdr[7]};
    assign dst     = {hdr[16], hdr[17], hdr[18], hdr[19]};
    assign tlen    = {hdr[2], hdr[3]};

    always_comb begin
        o_result = '0;
        if (size < COUNT_W'(HEADER_BYTES)) begin
            o_result.verdict = V_SHORT_HDR;
        end else begin
            o_result.total_length    = tlen;
            o_result.protocol_number = hdr[9];
            o_result.source_ip       = {hdr[12], hdr[13], hdr[14], hdr[15]};
            o_result.payload_length  = size - COUNT_W'(HEADER_BYTES);
            if (size < tlen) begin
                o_result.verdict = V_SHORT_PKT;
            end else begin
                o_result.learn_source = 1'b1;
                if (version != IP_VERSION4) begin
                    o_result.verdict = V_VERSION;
                end else if (ihl != IHL_NO_OPTS) begin
                    o_result.verdict = V_IHL;
                end else if (dst != i_local_addr) begin
                    o_result.verdict = V_DEST;
                end else if (frag != 13'd0) begin
                    o_result.verdict = V_FRAG;
                end else if (hdr[9] == PROTO_ICMP) begin
                    o_result.verdict = V_ICMP;
                end else if (hdr[9] == PROTO_UDP) begin
                    o_result.verdict = V_UDP;
                end else begin
                    o_result.verdict = V_OTHER;
                end
            end
        end
    end

endmodule

/* design/ipv4_receive_header_filter.sv */
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter
// The verdict sits in the single result register stage and appears in the
// cycle after the final byte is taken. One byte per cycle while no verdict waits.
// Reset (synchronous, active low) clears the byte count, the local address
// and the result valid flag; the header bytes need no reset.
// ----------------------------------------------------------------------------
module ipv4_receive_header_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_data,
    ipv4rhf_in_if.sink           i_in,
    ipv4rhf_out_if.source        o_out
);
    import ipv4rhf_pkg::*;

    // State carried from byte to byte: the running count and the header copy.
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    t_header            r_store;
    logic [31:0]        r_local_addr;

    // Result register with its valid flag.
    logic               r_out_valid;
    t_result            r_result;
    t_result            n_result;

    logic               in_fire;
    logic               fin_fire;

    // A byte is taken whenever the result register is empty or being drained,
    // so a waiting verdict holds back the next byte of the stream.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign fin_fire   = in_fire && i_in.last_byte;

    // The count saturates so that very long packets judge as the maximum size.
    assign n_count = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + COUNT_W'(1);

    ipv4rhf_judge u_judge (
        .i_store      (r_store),
        .i_data_byte  (i_in.data_byte),
        .i_count      (r_count),
        .i_local_addr (r_local_addr),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_local_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_local_addr <= i_cfg_data;
            end
            if (in_fire) begin
                r_count <= i_in.last_byte ? '0 : n_count;
            end
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Header bytes land at the position given by the count; only the first
    // twenty bytes of a packet are kept.
    always_ff @(posedge i_clk) begin
        if (in_fire && (r_count < COUNT_W'(HEADER_BYTES))) begin
            r_store[r_count[HDR_IDX_W-1:0]] <= i_in.data_byte;
        end
        if (fin_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.verdict         = r_result.verdict;
    assign o_out.learn_source    = r_result.learn_source;
    assign o_out.source_ip       = r_result.source_ip;
    assign o_out.protocol_number = r_result.protocol_number;
    assign o_out.total_length    = r_result.total_length;
    assign o_out.payload_length  = r_result.payload_length;

endmodule

/* tb/ipv4_receive_header_filter_checker.sv */
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter_checker
// Watches the byte and verdict channels and the address port of the IPv4
// receive header filter. It predicts each verdict from the accepted bytes and
// compares every accepted verdict, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ipv4_receive_header_filter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    ipv4rhf_in_if       i_in,
    ipv4rhf_out_if      i_out,
    output int          o_fail_count,
    output int          o_verdicts_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4rhf_pkg::*;

    logic [31:0] own_addr;
    int unsigned rx_count;
    logic [7:0]  hdr_bytes [HEADER_BYTES];
    t_result     verdict_queue [$];
    int          mismatches;
    int          pending;

    assign o_fail_count       = mismatches;
    assign o_verdicts_pending = pending;

    // Takes one byte of the current packet. Returns 1 with the predicted
    // verdict when the byte closes the packet.
    function automatic bit take_byte(input logic [7:0] b, input logic l,
                                     output t_result r);
        int unsigned size;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [12:0] frag;
        logic [31:0] dst;
        r = '0;
        if (rx_count < HEADER_BYTES) begin
            hdr_bytes[rx_count] = b;
        end
        if (rx_count < COUNT_MAX) begin
            rx_count++;
        end
        if (!l) begin
            return 1'b0;
        end
        size     = rx_count;
        rx_count = 0;
        if (size < HEADER_BYTES) begin
            r.verdict = V_SHORT_HDR;
            return 1'b1;
        end
        ver  = hdr_bytes[0][7:4];
        ihl  = hdr_bytes[0][3:0];
        frag = {hdr_bytes[6][4:0] & FRAG_HI_MASK, hdr_bytes[7]};
        dst  = {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
        r.total_length    = {hdr_bytes[2], hdr_bytes[3]};
        r.protocol_number = hdr_bytes[9];
        r.source_ip       = {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
        r.payload_length  = 16'(size - HEADER_BYTES);
        if (size < r.total_length) begin
            r.verdict = V_SHORT_PKT;
        end else begin
            r.learn_source = 1'b1;
            if (ver != IP_VERSION4) begin
                r.verdict = V_VERSION;
            end else if (ihl != IHL_NO_OPTS) begin
                r.verdict = V_IHL;
            end else if (dst != own_addr) begin
                r.verdict = V_DEST;
            end else if (frag != '0) begin
                r.verdict = V_FRAG;
            end else if (r.protocol_number == PROTO_ICMP) begin
                r.verdict = V_ICMP;
            end else if (r.protocol_number == PROTO_UDP) begin
                r.verdict = V_UDP;
            end else begin
                r.verdict = V_OTHER;
            end
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, exp_v, act_v);
            mismatches++;
        end
    endtask

    initial begin
        mismatches = 0;
        pending    = 0;
        rx_count   = 0;
        own_addr   = '0;
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            own_addr = '0;
            rx_count = 0;
            verdict_queue.delete();
        end else begin
            // The verdict leaving now was caused by an earlier byte, so it is
            // matched before this edge's byte is taken.
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (verdict_queue.size() == 0) begin
                    $display("%0t: unexpected verdict, expected none, actual 0x%0h",
                             $time, i_out.verdict);
                    mismatches++;
                end else begin
                    exp_r = verdict_queue.pop_front();
                    check_field("verdict", 32'(exp_r.verdict), 32'(i_out.verdict));
                    check_field("learn_source", 32'(exp_r.learn_source),
                                32'(i_out.learn_source));
                    check_field("source_ip", exp_r.source_ip, i_out.source_ip);
                    check_field("protocol_number", 32'(exp_r.protocol_number),
                                32'(i_out.protocol_number));
                    check_field("total_length", 32'(exp_r.total_length),
                                32'(i_out.total_length));
                    check_field("payload_length", 32'(exp_r.payload_length),
                                32'(i_out.payload_length));
                end
            end
            if (i_cfg_we === 1'b1) begin
                own_addr = i_cfg_data;
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                if (take_byte(i_in.data_byte, i_in.last_byte, exp_r)) begin
                    verdict_queue.push_back(exp_r);
                end
            end
        end
        pending = verdict_queue.size();
    end

endmodule

/* tb/ipv4_receive_header_filter_test.sv */
// ----------------------------------------------------------------------------
// ipv4_receive_header_filter_test
// Drives packets into the IPv4 receive header filter and gives the verdict.
// A short directed run covers the smallest packet, an exact 20-byte header and
// extreme field values; random packets then hit every verdict under four
// settings of the local address and four patterns of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module ipv4_receive_header_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4rhf_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;

    // Percentages of cycles in which the sender holds back a request and the
    // receiver refuses a verdict. The stimulus changes them per phase.
    int send_idle_pct;
    int stall_pct;

    // Bookkeeping of what has been sent, used only to pace the phases.
    int bytes_sent;
    int packets_sent;
    int cycles;

    // The address the block currently compares destinations against.
    logic [31:0] own_address;

    // The packet being assembled before it is sent.
    logic [7:0] frame [$];

    int fail_count;
    int pending;

    ipv4rhf_in_if  req_ch ();
    ipv4rhf_out_if verdict_ch ();

    ipv4_receive_header_filter uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (req_ch),
        .o_out      (verdict_ch)
    );

    ipv4_receive_header_filter_checker verdict_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_in               (req_ch),
        .i_out              (verdict_ch),
        .o_fail_count       (fail_count),
        .o_verdicts_pending (pending)
    );

    always #5ns clk = ~clk;

    // The receiver decides afresh at every falling edge whether it takes a
    // verdict, so stalls land on every phase of the block's work.
    always @(negedge clk) begin
        verdict_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: a lost verdict or a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sends one byte request. It is entered at a falling edge and returns at
    // the falling edge after the byte was accepted, with valid still high, so
    // that the caller either sends the next byte or lowers valid in that step.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.data_byte <= b;
        req_ch.last_byte <= l;
        @(posedge clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i]) begin
            send_byte(frame[i], i == frame.size() - 1);
        end
        packets_sent++;
    endtask

    // Puts a 20-byte header into the frame. Fields that no check looks at
    // (type of service, identification, TTL, checksum) get random values.
    task automatic build_header(input logic [7:0] ver_ihl, input logic [15:0] tlen,
                                input logic [7:0] flags_hi, input logic [7:0] frag_lo,
                                input logic [7:0] proto, input logic [31:0] src,
                                input logic [31:0] dst);
        logic [159:0] hdr_bits;
        hdr_bits = {ver_ihl, 8'($urandom), tlen, 16'($urandom), flags_hi, frag_lo,
                    8'($urandom), proto, 16'($urandom), src, dst};
        frame.delete();
        for (int i = 0; i < HEADER_BYTES; i++) begin
            frame.push_back(hdr_bits[159 - 8 * i -: 8]);
        end
    endtask

    // Changes the local address. The byte channel is quiet and every verdict
    // must be out first; the extra cycles let the result stage settle.
    task automatic set_local_address(input logic [31:0] addr);
        req_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_data    <= addr;
        own_address = addr;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random packet. Most packets are well-formed headers with random
    // content, steered toward one verdict each; failing cases also corrupt
    // lower-priority fields so that the order of the checks is exercised.
    // A few are plain noise or fragments shorter than a header.
    task automatic send_random_packet();
        int          roll;
        int          size;
        logic [15:0] tlen;
        logic [7:0]  ver_ihl;
        logic [7:0]  flags_hi;
        logic [7:0]  frag_lo;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [31:0] flip;
        logic [12:0] frag;
        logic [3:0]  bad_nibble;
        roll = $urandom_range(0, 99);
        if (roll < 14) begin
            // Noise of one to 40 bytes, or a fragment that never fills a header.
            frame.delete();
            repeat ((roll < 6) ? $urandom_range(1, 40) : $urandom_range(1, HEADER_BYTES - 1))
                frame.push_back(8'($urandom));
            send_frame();
            return;
        end
        size     = HEADER_BYTES + $urandom_range(0, 8);
        tlen     = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, size)) : 16'(size);
        ver_ihl  = {IP_VERSION4, IHL_NO_OPTS};
        flags_hi = {3'($urandom_range(0, 7)), 5'b00000};
        frag_lo  = 8'h00;
        dst      = own_address;
        case ($urandom_range(0, 2))
            0:       proto = PROTO_ICMP;
            1:       proto = PROTO_UDP;
            default: proto = 8'($urandom);
        endcase
        if (roll < 22) begin
            // Total length beyond what arrived; version, IHL and destination random too.
            tlen    = 16'($urandom_range(size + 1, 65535));
            ver_ihl = 8'($urandom);
            dst     = $urandom;
        end else if (roll < 30) begin
            bad_nibble = 4'($urandom_range(0, 14));
            if (bad_nibble >= IP_VERSION4) begin
                bad_nibble++;
            end
            ver_ihl = {bad_nibble, 4'($urandom)};
            dst     = $urandom;
        end else if (roll < 38) begin
            bad_nibble = 4'($urandom_range(0, 14));
            if (bad_nibble >= IHL_NO_OPTS) begin
                bad_nibble++;
            end
            ver_ihl[3:0] = bad_nibble;
            dst          = $urandom;
        end else if (roll < 48) begin
            flip = $urandom;
            if (flip == '0) begin
                flip = 32'h1;
            end
            dst      = own_address ^ flip;
            flags_hi = 8'($urandom);
            frag_lo  = 8'($urandom);
        end else if (roll < 58) begin
            frag     = 13'($urandom_range(1, 8191));
            flags_hi = {3'($urandom_range(0, 7)), frag[12:8]};
            frag_lo  = frag[7:0];
        end
        build_header(ver_ihl, tlen, flags_hi, frag_lo, proto, $urandom, dst);
        while (frame.size() < size) begin
            frame.push_back(8'($urandom));
        end
        send_frame();
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input logic [31:0] addr,
                             input int n_bytes, input int n_packets);
        int b0;
        int p0;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        set_local_address(addr);
        b0 = bytes_sent;
        p0 = packets_sent;
        while (bytes_sent - b0 < n_bytes || packets_sent - p0 < n_packets) begin
            send_random_packet();
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.data_byte    = '0;
        req_ch.last_byte    = 1'b0;
        verdict_ch.ready    = 1'b0;
        send_idle_pct       = 0;
        stall_pct           = 0;
        bytes_sent          = 0;
        packets_sent        = 0;
        cycles              = 0;
        own_address         = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase one: no idling on either side, local address all zeros.
        set_local_address(32'h0000_0000);

        // Directed: the smallest possible packet, a single all-ones byte,
        // which is far too short to hold a header.
        frame.delete();
        frame.push_back(8'hFF);
        send_frame();

        // Directed: a packet of exactly one header and no payload. All flag
        // bits set with a zero offset must still pass, and the all-ones
        // source address must come through unchanged.
        build_header({IP_VERSION4, IHL_NO_OPTS}, 16'(HEADER_BYTES), 8'hE0, 8'h00,
                     PROTO_ICMP, 32'hFFFF_FFFF, own_address);
        send_frame();

        run_phase(0, 0, 32'h0000_0000, 205, 9);

        // Remaining phases: all-ones address with a gappy sender, a random
        // address with a stalling receiver, then another random address
        // with both sides idling now and then.
        run_phase(47, 0, 32'hFFFF_FFFF, 205, 9);
        run_phase(0, 47, $urandom, 205, 9);
        run_phase(18, 18, $urandom, 205, 9);

        req_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
